>>> hdl/crc32_frame_checker_core_macros.svh
// assertion macros for the crc32 frame checker
`ifndef CRC32_FRAME_CHECKER_CORE_MACROS_SVH
`define CRC32_FRAME_CHECKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRCFC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crcfc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CRCFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crcfc assertion failed");

`endif

>>> hdl/crcfc_pkg.sv
// shared types, constants and the byte-wide crc update for the frame checker
`default_nettype none

package crcfc_pkg;

	localparam int MaxFrameBytes = 1024;
	localparam int CntW          = $clog2(MaxFrameBytes + 1);
	localparam int EplW          = 10;
	localparam int CmpW          = (CntW > EplW) ? CntW : EplW;
	localparam int TrailerBytes  = 4;
	localparam int QueueDepth    = 2;
	localparam int QPtrW         = $clog2(QueueDepth);
	localparam int QCntW         = $clog2(QueueDepth + 1);

	localparam logic [31:0]     CrcPoly  = 32'hEDB8_8320;
	localparam logic [31:0]     CrcOnes  = 32'hFFFF_FFFF;
	localparam logic [EplW-1:0] EplReset = EplW'(16);

	typedef enum logic [1:0] {
		StatusGood   = 2'd0,
		StatusLenErr = 2'd1,
		StatusCrcErr = 2'd2
	} status_t;

	// one command from the front to the back, one per accepted byte
	typedef struct packed {
		logic        feed;
		logic [7:0]  feed_byte;
		logic        last;
		logic        len_err;
		logic [31:0] window;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] computed_crc;
		logic [31:0] received_crc;
	} res_t;

	function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] data);
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/crcfc_front.sv
// front end: trailer window, byte count and length check, one command per byte
`default_nettype none

module crcfc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          last_byte,
	input  wire logic [crcfc_pkg::EplW-1:0]    expected_payload_len,
	output crcfc_pkg::cmd_t                    cmd
);

	logic [crcfc_pkg::CntW-1:0] count_q;
	logic [31:0]                window_q;
	logic [31:0]                window_next;
	logic [crcfc_pkg::CntW-1:0] payload_len;
	logic                       saturated;
	logic                       too_short;
	logic                       len_mismatch;

	assign window_next = {data_byte, window_q[31:8]};
	assign saturated   = (count_q >= crcfc_pkg::CntW'(crcfc_pkg::MaxFrameBytes));
	assign too_short   = (count_q < crcfc_pkg::CntW'(crcfc_pkg::TrailerBytes));
	// count already excludes the current byte, so payload is count + 1 - trailer
	assign payload_len = count_q - crcfc_pkg::CntW'(crcfc_pkg::TrailerBytes - 1);
	assign len_mismatch = (crcfc_pkg::CmpW'(payload_len) !=
		crcfc_pkg::CmpW'(expected_payload_len));

	always_comb begin
		cmd.feed      = !too_short;
		cmd.feed_byte = window_q[7:0];
		cmd.last      = last_byte;
		cmd.len_err   = saturated || too_short || len_mismatch;
		cmd.window    = window_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			window_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q  <= '0;
				window_q <= '0;
			end else begin
				window_q <= window_next;
				if (!saturated) begin
					count_q <= count_q + crcfc_pkg::CntW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/crcfc_queue.sv
// short command queue between the front and the back
`default_nettype none

module crcfc_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire crcfc_pkg::cmd_t push_item,
	output logic       full,
	input  wire logic  pop,
	output crcfc_pkg::cmd_t pop_item,
	output logic       not_empty
);

	crcfc_pkg::cmd_t             slot_q [crcfc_pkg::QueueDepth];
	logic [crcfc_pkg::QPtrW-1:0] wr_ptr_q;
	logic [crcfc_pkg::QPtrW-1:0] rd_ptr_q;
	logic [crcfc_pkg::QCntW-1:0] cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full      = (cnt_q == crcfc_pkg::QCntW'(crcfc_pkg::QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + crcfc_pkg::QPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + crcfc_pkg::QPtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + crcfc_pkg::QCntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - crcfc_pkg::QCntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/crcfc_back.sv
// back end: running crc, frame verdict and the result register
`default_nettype none

module crcfc_back (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	input  wire crcfc_pkg::cmd_t cmd,
	output logic       cmd_take,
	output logic       res_valid,
	output crcfc_pkg::res_t res,
	input  wire logic  res_pop
);

	logic [31:0]        crc_q;
	logic [31:0]        crc_next;
	logic [31:0]        crc_final;
	logic               res_valid_q;
	crcfc_pkg::res_t    res_q;
	crcfc_pkg::status_t verdict;
	logic               res_room;
	logic               res_wr;
	logic               out_pop;

	assign out_pop   = res_pop && res_valid_q;
	assign res_room  = !res_valid_q || out_pop;
	// non-final bytes never need room in the result register
	assign cmd_take  = cmd_valid && (!cmd.last || res_room);
	assign res_wr    = cmd_take && cmd.last;
	assign crc_next  = cmd.feed ? crcfc_pkg::crc_feed(crc_q, cmd.feed_byte) : crc_q;
	assign crc_final = crc_next ^ crcfc_pkg::CrcOnes;

	always_comb begin
		priority if (cmd.len_err) begin
			verdict = crcfc_pkg::StatusLenErr;
		end else if (crc_final != cmd.window) begin
			verdict = crcfc_pkg::StatusCrcErr;
		end else begin
			verdict = crcfc_pkg::StatusGood;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_q.status       <= verdict;
			res_q.computed_crc <= crc_final;
			res_q.received_crc <= cmd.window;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= crcfc_pkg::CrcOnes;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				crc_q <= cmd.last ? crcfc_pkg::CrcOnes : crc_next;
			end
			if (res_wr) begin
				res_valid_q <= 1'b1;
			end else if (out_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/crc32_frame_checker_core.sv
// Frame checker taking one byte per clock and giving one result per frame. A byte is
// taken on any cycle with push high and full low, so the sustained rate is one item per
// cycle, set by the byte-wide crc update in the back end; the front end forms a command for each
// byte and pushes it into a two-entry command queue, and the back end drains it at one command per
// cycle while the result register has room for a final byte. With the queue otherwise empty, the
// result of a frame passes through the queue slot and then the result register to reach the result
// ports, and it stays until popped; the back end keeps draining non-final bytes meanwhile, and full
// rises only once the queue fills behind an unpopped result. No clearing pass after reset.
// expected_payload_len resets to 16 and may be written only while no frame is in flight.
`default_nettype none

`include "crc32_frame_checker_core_macros.svh"

module crc32_frame_checker_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       last_byte,
	output logic                            empty,
	input  wire logic                       pop,
	output logic [1:0]                      status,
	output logic [31:0]                     computed_crc,
	output logic [31:0]                     received_crc,
	input  wire logic                       cfg_wr_en,
	input  wire logic [crcfc_pkg::EplW-1:0] cfg_wr_data
);

	logic [crcfc_pkg::EplW-1:0] epl_q;
	logic                       in_accept;
	crcfc_pkg::cmd_t            front_cmd;
	crcfc_pkg::cmd_t            q_cmd;
	logic                       q_not_empty;
	logic                       cmd_take;
	logic                       res_valid;
	crcfc_pkg::res_t            res;

	assign in_accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epl_q <= crcfc_pkg::EplReset;
		end else if (cfg_wr_en) begin
			epl_q <= cfg_wr_data;
		end
	end

	crcfc_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.accept               (in_accept),
		.data_byte            (data_byte),
		.last_byte            (last_byte),
		.expected_payload_len (epl_q),
		.cmd                  (front_cmd)
	);

	crcfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_cmd),
		.full      (full),
		.pop       (cmd_take),
		.pop_item  (q_cmd),
		.not_empty (q_not_empty)
	);

	crcfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_cmd),
		.cmd_take  (cmd_take),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	assign empty        = !res_valid;
	assign status       = res.status;
	assign computed_crc = res.computed_crc;
	assign received_crc = res.received_crc;

	// a good verdict means the two crc values agree
	`CRCFC_ASSERT_SAME(a_good_means_match, !empty && status == crcfc_pkg::StatusGood, computed_crc == received_crc)
	// a final byte leaving the queue always produces a visible result
	`CRCFC_ASSERT_NEXT(a_last_gives_result, cmd_take && q_cmd.last, !empty)
	// no result appears without a final byte being processed
	`CRCFC_ASSERT_NEXT(a_no_spurious_result, empty && !(cmd_take && q_cmd.last), empty)

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the crc32 frame checker core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] octets_t[$];

	// tracks the frame in progress and holds the verdicts still owed by the block
	class frame_tracker;
		localparam logic [31:0] Poly = 32'hEDB8_8320;

		logic [31:0]                crc_acc;
		logic [31:0]                tail;
		logic [10:0]                bytes_in;
		logic [crcfc_pkg::EplW-1:0] want_len;
		crcfc_pkg::res_t            pending_verdicts[$];
		int                         errors;

		function new();
			want_len = 10'd16;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			crc_acc = '1;
			tail = '0;
			bytes_in = '0;
		endfunction

		static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = {1'b0, c[31:1]} ^ (fb ? Poly : 32'h0);
			end
			return c;
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction

		function void take_byte(logic [7:0] d, logic l);
			crcfc_pkg::res_t r;
			int unsigned len;
			// the byte leaving the window goes into the crc
			if (bytes_in >= 4)
				crc_acc = crc_step(crc_acc, tail[7:0]);
			tail = {d, tail[31:8]};
			if (!l) begin
				if (bytes_in < crcfc_pkg::MaxFrameBytes)
					bytes_in++;
				return;
			end
			len = int'(bytes_in) + 1;
			if (bytes_in >= crcfc_pkg::MaxFrameBytes || len <= 4 ||
				len - 4 != int'(want_len))
				r.status = crcfc_pkg::StatusLenErr;
			else if (~crc_acc != tail)
				r.status = crcfc_pkg::StatusCrcErr;
			else
				r.status = crcfc_pkg::StatusGood;
			r.computed_crc = ~crc_acc;
			r.received_crc = tail;
			pending_verdicts.push_back(r);
			clear_frame();
		endfunction

		function void match_result(logic [1:0] st, logic [31:0] cc, logic [31:0] rc);
			crcfc_pkg::res_t e;
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: status %0d computed_crc %h received_crc %h",
					st, cc, rc);
				errors++;
				return;
			end
			e = pending_verdicts.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (cc !== e.computed_crc) begin
				$error("computed_crc: expected %h, got %h", e.computed_crc, cc);
				errors++;
			end
			if (rc !== e.received_crc) begin
				$error("received_crc: expected %h, got %h", e.received_crc, rc);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic [7:0]                 data_byte = '0;
	logic                       last_byte = 1'b0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [1:0]                 status;
	logic [31:0]                computed_crc;
	logic [31:0]                received_crc;
	logic                       cfg_wr_en = 1'b0;
	logic [crcfc_pkg::EplW-1:0] cfg_wr_data = '0;

	frame_tracker frames = new();
	bit           tx_idle = 1'b1;
	bit           rx_idle = 1'b1;
	bit           hold_rx = 1'b0;
	int           items_sent = 0;

	crc32_frame_checker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.computed_crc (computed_crc),
		.received_crc (received_crc),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (full);
		frames.take_byte(d, l);
		items_sent++;
	endtask

	task automatic send_bytes(input octets_t octets);
		foreach (octets[i])
			send_byte(octets[i], i == octets.size() - 1);
	endtask

	// payload of plen bytes and a little-endian crc trailer; fill < 0 means random payload
	task automatic send_frame(input int plen, input bit good_crc, input int fill);
		octets_t     octets;
		logic [7:0]  b;
		logic [31:0] c;
		c = '1;
		for (int i = 0; i < plen; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			octets.push_back(b);
			c = frame_tracker::crc_step(c, b);
		end
		c = ~c;
		if (!good_crc)
			c ^= 32'h1 << $urandom_range(0, 31);
		for (int k = 0; k < 4; k++)
			octets.push_back(c[8*k +: 8]);
		send_bytes(octets);
	endtask

	task automatic send_noise(input int n);
		octets_t octets;
		for (int i = 0; i < n; i++)
			octets.push_back(8'($urandom));
		send_bytes(octets);
	endtask

	// wait for every owed result, then let the back end go quiet
	task automatic settle();
		push <= 1'b0;
		while (frames.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [crcfc_pkg::EplW-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		frames.want_len = v;
	endtask

	task automatic run_phase(input int want, input int nframes);
		int pick;
		int plen;
		for (int f = 0; f < nframes; f++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				plen = (want == 0 || want > 64) ? $urandom_range(1, 40) : want;
				send_frame(plen, 1'b1, -1);
			end else if (pick < 78) begin
				plen = (want == 0 || want > 64) ? $urandom_range(1, 40) : want;
				send_frame(plen, 1'b0, -1);
			end else if (pick < 88) begin
				plen = (want > 64) ? $urandom_range(0, 40) : $urandom_range(0, want + 6);
				send_frame(plen, 1'b1, -1);
			end else if (pick < 94) begin
				send_noise($urandom_range(1, 4));
			end else begin
				send_noise($urandom_range(5, 45));
			end
		end
	endtask

	initial begin : result_side
		int w;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				w = 80;
				hold_rx = 1'b0;
			end else begin
				w = rx_idle ? $urandom_range(0, 15) : 0;
			end
			if (w > 0) begin
				pop <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			frames.match_result(status, computed_crc, received_crc);
		end
	end

	initial begin : frame_side
		int want;
		int r;
		octets_t octets;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a random mix, mostly good frames, at the length the block comes out of reset with
		run_phase(16, 6);

		// short frames, a one-byte payload good and with a bad crc, wrong length
		settle();
		octets = {8'hFF};
		send_bytes(octets);
		octets = {8'h00, 8'h00, 8'h00, 8'h00};
		send_bytes(octets);
		settle();
		write_cfg(10'd1);
		send_frame(1, 1'b1, 8'hFF);
		send_frame(1, 1'b0, 8'h00);
		send_frame(2, 1'b1, -1);
		// a zero length can never be met
		settle();
		write_cfg(10'd0);
		send_frame(1, 1'b1, -1);
		send_frame(0, 1'b1, -1);

		// results pile up behind a stalled receiver until full rises
		settle();
		write_cfg(10'd3);
		tx_idle = 1'b0;
		hold_rx = 1'b1;
		repeat (12) send_byte(8'($urandom), 1'b1);
		tx_idle = 1'b1;

		// one byte past the frame limit with a payload length that would match
		settle();
		write_cfg(10'd1021);
		send_frame(1021, 1'b1, -1);

		while (items_sent < 1850) begin
			settle();
			r = $urandom_range(0, 19);
			if (r == 0)
				want = 0;
			else if (r == 1)
				want = 1023;
			else if (r == 2)
				want = 1;
			else
				want = $urandom_range(2, 40);
			write_cfg(crcfc_pkg::EplW'(want));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			run_phase(want, $urandom_range(3, 8));
		end

		settle();
		repeat (10) @(posedge clk);
		if (frames.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
